// ===== src/hqva_pkg.sv =====
// Package for the harmonic Q-vector accumulator.
// Types and constants shared by the controller, the datapath and the top level.
package hqva_pkg;

  localparam int SumW = 48;
  localparam int WgtW = 30;
  localparam int MagW = 47;
  localparam int CordW = 50;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [WgtW-1:0] WgtMax = '1;
  localparam logic [MagW-1:0] MagMax = '1;
  localparam logic [31:0] InvGain = 32'd652032874;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  localparam logic [1:0] RegEtaMin = 2'd0;
  localparam logic [1:0] RegEtaMax = 2'd1;
  localparam logic [1:0] RegHarmonic = 2'd2;

  // arctangent table, turn units in 32 bits
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: return 32'd536870912;
      5'd1: return 32'd316933406;
      5'd2: return 32'd167458907;
      5'd3: return 32'd85004756;
      5'd4: return 32'd42667331;
      5'd5: return 32'd21354465;
      5'd6: return 32'd10679838;
      5'd7: return 32'd5340245;
      5'd8: return 32'd2670163;
      5'd9: return 32'd1335087;
      5'd10: return 32'd667544;
      5'd11: return 32'd333772;
      5'd12: return 32'd166886;
      5'd13: return 32'd83443;
      5'd14: return 32'd41722;
      5'd15: return 32'd20861;
      5'd16: return 32'd10430;
      5'd17: return 32'd5215;
      5'd18: return 32'd2608;
      5'd19: return 32'd1304;
      5'd20: return 32'd652;
      5'd21: return 32'd326;
      5'd22: return 32'd163;
      5'd23: return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ROT    = 5'b00010,
    ST_ACC    = 5'b00100,
    ST_POLAR  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic rot_step;  // one rotation-mode CORDIC step
    logic acc;       // add the tower to the sums
    logic pol_load;  // load vectoring CORDIC for set pol_set
    logic pol_step;  // one vectoring step
    logic pol_store; // store result of set pol_set
    logic [1:0] pol_set;
    logic clear;     // clear sums after result
  } cmd_t;

  typedef struct packed {
    logic last;    // captured word is last of event
    logic counted; // captured tower is present, in window and under limit
  } status_t;

endpackage

// ===== src/hqva_if.sv =====
// Valid/ready channel interfaces for the Q-vector accumulator.
// Depends on nothing.
interface hqva_tower_if;
  logic valid;
  logic ready;
  logic tower_present;
  logic signed [11:0] tower_eta;
  logic [15:0] tower_phi;
  logic [15:0] em_et;
  logic [15:0] had_et;
  logic last_tower;
  modport source (output valid, tower_present, tower_eta, tower_phi, em_et, had_et,
                  last_tower, input ready);
  modport sink (input valid, tower_present, tower_eta, tower_phi, em_et, had_et,
                last_tower, output ready);
endinterface

interface hqva_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_all;
  logic signed [15:0] angle_plus;
  logic signed [15:0] angle_minus;
  logic [46:0] magnitude_all;
  logic [46:0] magnitude_plus;
  logic [46:0] magnitude_minus;
  logic [29:0] weight_all;
  logic [29:0] weight_plus;
  logic [29:0] weight_minus;
  modport source (output valid, angle_all, angle_plus, angle_minus, magnitude_all,
                  magnitude_plus, magnitude_minus, weight_all, weight_plus,
                  weight_minus, input ready);
  modport sink (input valid, angle_all, angle_plus, angle_minus, magnitude_all,
                magnitude_plus, magnitude_minus, weight_all, weight_plus,
                weight_minus, output ready);
endinterface

interface hqva_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/hqva_ctrl.sv =====
// Controller FSM for the Q-vector accumulator.
// Depends on hqva_pkg.
module hqva_ctrl import hqva_pkg::*; #(
  parameter int TRIG_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int StepW = $clog2(TRIG_BITS + 2);
  localparam logic [StepW-1:0] LastStep = StepW'(TRIG_BITS - 1);

  state_t state, state_next;
  logic [StepW-1:0] step, step_next;
  logic [1:0] set, set_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      set <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
      set <= set_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next = step;
    set_next = set;
    cmd = '0;
    cmd.pol_set = set;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          step_next = '0;
          state_next = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd.rot_step = 1'b1;
        step_next = step + 1'b1;
        if (step == LastStep) state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = status.counted;
        if (status.last) begin
          set_next = '0;
          cmd.pol_set = 2'd0;
          state_next = ST_POLAR;
          step_next = '0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_POLAR: begin
        // step 0 loads, 1..TRIG_BITS iterate, then store
        if (step == '0) begin
          cmd.pol_load = 1'b1;
          step_next = step + 1'b1;
        end else if (step == StepW'(TRIG_BITS + 1)) begin
          cmd.pol_store = 1'b1;
          step_next = '0;
          if (set == 2'd2) state_next = ST_OUT;
          else set_next = set + 1'b1;
        end else begin
          cmd.pol_step = 1'b1;
          step_next = step + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_set: assert property (@(posedge clk) disable iff (rst) set != 2'd3)
    else $error("set index out of range");
  a_store_out: assert property (@(posedge clk) disable iff (rst)
    cmd.pol_store && set == 2'd2 |=> out_valid)
    else $error("result not presented after last set");

endmodule

// ===== src/hqva_dp.sv =====
// Datapath: window test, rotation CORDIC, saturating sums, vectoring CORDIC.
// Depends on hqva_pkg.
module hqva_dp import hqva_pkg::*; #(
  parameter int MAX_TOWERS = 4096,
  parameter int TRIG_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               tower_present,
  input  logic signed [11:0] tower_eta,
  input  logic [15:0]        tower_phi,
  input  logic [15:0]        em_et,
  input  logic [15:0]        had_et,
  input  logic               last_tower,
  input  logic [10:0]        eta_min,
  input  logic [10:0]        eta_max,
  input  logic [3:0]         harmonic,
  output logic signed [15:0] angle [3],
  output logic [MagW-1:0]    magnitude [3],
  output logic [WgtW-1:0]    weight [3]
);

  localparam int CntW = $clog2(MAX_TOWERS + 1);
  localparam int StepW = $clog2(TRIG_BITS + 1);

  // captured word
  logic last, present, pos, in_win, under;
  logic [16:0] et;
  logic [CntW-1:0] count;
  logic [StepW-1:0] rstep;
  logic signed [33:0] rx, ry, rz;
  logic neg;

  logic signed [12:0] eta_ext, aeta;
  logic [15:0] phase;
  logic [31:0] z0;
  logic signed [33:0] zs;

  always_comb begin
    eta_ext = 13'(tower_eta);
    aeta = tower_eta[11] ? -eta_ext : eta_ext;
    phase = 16'(harmonic * tower_phi);
    z0 = {phase, 16'd0};
    zs = {{2{z0[31]}}, z0};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last <= last_tower;
      present <= tower_present;
      pos <= !tower_eta[11] && tower_eta != 12'sd0;
      in_win <= (aeta > $signed({2'b0, eta_min})) && (aeta < $signed({2'b0, eta_max}));
      // tower limit is judged on the count before this tower
      under <= count < CntW'(MAX_TOWERS);
      et <= {1'b0, em_et} + {1'b0, had_et};
      rx <= 34'sd652032874;
      ry <= '0;
      rstep <= '0;
      if (zs > $signed({2'b0, QuarterTurn})) begin
        rz <= zs - $signed({2'b0, HalfTurn}); neg <= 1'b1;
      end else if (zs < -$signed({2'b0, QuarterTurn})) begin
        rz <= zs + $signed({2'b0, HalfTurn}); neg <= 1'b1;
      end else begin
        rz <= zs; neg <= 1'b0;
      end
    end else if (cmd.rot_step) begin
      if (!rz[33]) begin
        rx <= rx - (ry >>> rstep);
        ry <= ry + (rx >>> rstep);
        rz <= rz - $signed({2'b0, atan_turn(5'(rstep))});
      end else begin
        rx <= rx + (ry >>> rstep);
        ry <= ry - (rx >>> rstep);
        rz <= rz + $signed({2'b0, atan_turn(5'(rstep))});
      end
      rstep <= rstep + 1'b1;
    end
  end

  assign status.last = last;
  assign status.counted = present && under && in_win;

  // rounded, signed-corrected, clamped cos/sin
  function automatic logic signed [15:0] q15(input logic signed [33:0] v,
                                              input logic n);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd16384) >>> 15;
      if (n) r = -r;
      if (r > 34'sd32767) return 16'sd32767;
      if (r < -34'sd32767) return -16'sd32767;
      return 16'(r);
    end
  endfunction

  logic signed [15:0] c, s;
  logic signed [SumW-1:0] re, im;
  assign c = q15(rx, neg);
  assign s = q15(ry, neg);
  assign re = SumW'($signed({1'b0, et}) * c);
  assign im = SumW'($signed({1'b0, et}) * s);

  logic signed [SumW-1:0] sre [3], sim [3];
  logic [WgtW-1:0] wgt [3];

  function automatic logic signed [SumW-1:0] sat(input logic signed [SumW-1:0] a,
                                                 input logic signed [SumW-1:0] b);
    logic signed [SumW:0] r;
    begin
      r = {a[SumW-1], a} + {b[SumW-1], b};
      if (r > $signed({1'b0, SumMax})) return SumMax;
      if (r < $signed({1'b1, SumMin})) return SumMin;
      return r[SumW-1:0];
    end
  endfunction

  function automatic logic [WgtW-1:0] wsat(input logic [WgtW-1:0] a,
                                           input logic [16:0] b);
    logic [WgtW:0] r;
    begin
      r = {1'b0, a} + (WgtW+1)'(b);
      return r[WgtW] ? WgtMax : r[WgtW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      for (int k = 0; k < 3; k++) begin
        sre[k] <= '0; sim[k] <= '0; wgt[k] <= '0;
      end
    end else if (cmd.acc) begin
      sre[0] <= sat(sre[0], re);
      sim[0] <= sat(sim[0], im);
      wgt[0] <= wsat(wgt[0], et);
      if (pos) begin
        sre[1] <= sat(sre[1], re);
        sim[1] <= sat(sim[1], im);
        wgt[1] <= wsat(wgt[1], et);
      end else begin
        sre[2] <= sat(sre[2], re);
        sim[2] <= sat(sim[2], im);
        wgt[2] <= wsat(wgt[2], et);
      end
    end
    // count every present tower that fits, counted or not
    if (!rst && !cmd.clear && cmd.rot_step && rstep == '0 && present &&
        count < CntW'(MAX_TOWERS))
      count <= count + 1'b1;
  end

  // vectoring CORDIC, shared by the three sets
  logic signed [CordW-1:0] vx, vy;
  logic [31:0] vz;
  logic [StepW-1:0] vstep;
  logic vzero;
  logic signed [CordW-1:0] lx, ly;
  assign lx = CordW'(sre[cmd.pol_set]);
  assign ly = CordW'(sim[cmd.pol_set]);

  always_ff @(posedge clk) begin
    if (cmd.pol_load) begin
      vzero <= (lx == '0) && (ly == '0);
      vstep <= '0;
      if (lx < 0) begin
        vx <= -lx; vy <= -ly; vz <= HalfTurn;
      end else begin
        vx <= lx; vy <= ly; vz <= '0;
      end
    end else if (cmd.pol_step) begin
      if (vy < 0) begin
        vx <= vx - (vy >>> vstep);
        vy <= vy + (vx >>> vstep);
        vz <= vz - atan_turn(5'(vstep));
      end else begin
        vx <= vx + (vy >>> vstep);
        vy <= vy - (vx >>> vstep);
        vz <= vz + atan_turn(5'(vstep));
      end
      vstep <= vstep + 1'b1;
    end
  end

  // magnitude scale: vx (non-negative, < 2^50) times 1/K, in two halves
  logic [CordW-1:0] ux;
  logic [63:0] lo, hi;
  logic [65:0] m;
  logic [31:0] zr;
  assign ux = vx;
  assign lo = {32'd0, ux[31:0]} * {32'd0, InvGain};
  assign hi = 64'(ux[CordW-1:32]) * {32'd0, InvGain};
  assign m = {hi, 2'b0} + 66'((lo + 64'd536870912) >> 30);
  assign zr = vz + 32'd32768;

  always_ff @(posedge clk) begin
    if (cmd.pol_store) begin
      angle[cmd.pol_set] <= vzero ? 16'sd0 : $signed(zr[31:16]);
      magnitude[cmd.pol_set] <= vzero ? '0 : (m > 66'(MagMax) ? MagMax : m[MagW-1:0]);
      weight[cmd.pol_set] <= wgt[cmd.pol_set];
    end
  end

endmodule

// ===== src/harmonic_q_vector_accumulator.sv =====
// Top level of the harmonic Q-vector accumulator.
// Depends on hqva_pkg, hqva_if, hqva_ctrl and hqva_dp.
//
// One tower word at a time: a tower is captured, then runs TRIG_BITS
// rotation-mode CORDIC steps for cos/sin of the harmonic phase, then an
// accumulate step, before the next word is taken. A last word then runs
// the one vectoring CORDIC unit over the three sums in turn, and holds the
// result word until it is taken; the sums clear on that handshake. Config
// may be written at any time.
module harmonic_q_vector_accumulator import hqva_pkg::*; #(
  parameter int MAX_TOWERS = 4096,
  parameter int TRIG_BITS = 16
) (
  input logic clk,
  input logic rst,
  hqva_tower_if.sink   tower,
  hqva_result_if.source result,
  hqva_cfg_if.sink     cfg
);

  logic [10:0] eta_min, eta_max;
  logic [3:0] harmonic;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      eta_min <= 11'd768;
      eta_max <= 11'd1280;
      harmonic <= 4'd2;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegEtaMin: eta_min <= cfg.data;
        RegEtaMax: eta_max <= cfg.data;
        RegHarmonic: harmonic <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  status_t status;
  logic signed [15:0] angle [3];
  logic [MagW-1:0] magnitude [3];
  logic [WgtW-1:0] weight [3];

  hqva_ctrl #(.TRIG_BITS(TRIG_BITS)) u_ctrl (
    .clk, .rst,
    .in_valid(tower.valid), .in_ready(tower.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .status, .cmd
  );

  hqva_dp #(.MAX_TOWERS(MAX_TOWERS), .TRIG_BITS(TRIG_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .tower_present(tower.tower_present), .tower_eta(tower.tower_eta),
    .tower_phi(tower.tower_phi), .em_et(tower.em_et), .had_et(tower.had_et),
    .last_tower(tower.last_tower),
    .eta_min, .eta_max, .harmonic,
    .angle, .magnitude, .weight
  );

  assign result.angle_all = angle[0];
  assign result.angle_plus = angle[1];
  assign result.angle_minus = angle[2];
  assign result.magnitude_all = magnitude[0];
  assign result.magnitude_plus = magnitude[1];
  assign result.magnitude_minus = magnitude[2];
  assign result.weight_all = weight[0];
  assign result.weight_plus = weight[1];
  assign result.weight_minus = weight[2];

endmodule
